### rtl/core/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg
// Shared widths, codes and control structs of the bitmap extent allocator.
// ----------------------------------------------------------------------------
package bea_pkg;

    localparam int MAX_CLUSTERS    = 2048;
    localparam int MAX_EXTENTS_DEF = 64;
    localparam int AW              = 11;   // cluster address
    localparam int LW              = 12;   // cluster count / length

    localparam logic [LW-1:0] CLUSTER_TOTAL_RST = 12'd1600;

    localparam logic [1:0] OP_FORMAT = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_BAD   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSPC  = 2'd1;
    localparam logic [1:0] ST_BADPOL = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    typedef struct packed {
        logic          start;    // clear run trackers
        logic          count;    // count ones only, no run evaluation
        logic          bit_vld;
        logic          bit_val;
        logic [AW-1:0] bit_idx;
        logic          flush;    // end of window, close open run
    } t_scan_ctl;

    typedef struct packed {
        logic          hit;      // exact / sufficient run found early
        logic          any;
        logic [AW-1:0] st;
        logic [LW-1:0] take;
    } t_scan_res;

endpackage

### rtl/core/bea_bitmap.sv
// ----------------------------------------------------------------------------
// bea_bitmap
// One bit per cluster free map, one write and one registered read port.
// ----------------------------------------------------------------------------
module bea_bitmap (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [bea_pkg::AW-1:0]  i_waddr,
    input  logic                    i_wdata,
    input  logic [bea_pkg::AW-1:0]  i_raddr,
    output logic                    o_rdata
);

    logic r_mem [bea_pkg::MAX_CLUSTERS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/bea_scan.sv
// ----------------------------------------------------------------------------
// bea_scan
// Bit-serial run tracker: counts free bits and ranks free runs by fit policy.
// ----------------------------------------------------------------------------
module bea_scan (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bea_pkg::t_scan_ctl      i_ctl,
    input  logic [1:0]              i_policy,
    input  logic [bea_pkg::LW-1:0]  i_need,
    output bea_pkg::t_scan_res      o_res,
    output logic [bea_pkg::LW-1:0]  o_ones
);

    localparam int AW = bea_pkg::AW;
    localparam int LW = bea_pkg::LW;

    logic [AW-1:0] r_run_st,  n_run_st;
    logic [LW-1:0] r_run_len, n_run_len;
    logic          r_any, n_any, r_big, n_big, r_small, n_small, r_hit, n_hit;
    logic [AW-1:0] r_ff, n_ff, r_a_st, n_a_st, r_b_st, n_b_st, r_h_st, n_h_st;
    logic [LW-1:0] r_a_len, n_a_len, r_b_len, n_b_len, r_h_take, n_h_take;
    logic [LW-1:0] r_ones, n_ones;
    logic          eval;

    always_comb begin
        n_run_st  = r_run_st;
        n_run_len = r_run_len;
        n_any = r_any;   n_ff = r_ff;
        n_big = r_big;   n_a_st = r_a_st; n_a_len = r_a_len;
        n_small = r_small; n_b_st = r_b_st; n_b_len = r_b_len;
        n_hit = r_hit;   n_h_st = r_h_st; n_h_take = r_h_take;
        n_ones = r_ones;
        eval = 1'b0;

        if (i_ctl.bit_vld) begin
            if (i_ctl.bit_val) begin
                n_ones = r_ones + LW'(1);
                if (r_run_len == '0) begin
                    n_run_st = i_ctl.bit_idx;
                end
                n_run_len = r_run_len + LW'(1);
            end else begin
                eval      = (r_run_len != '0);
                n_run_len = '0;
            end
        end
        if (i_ctl.flush) begin
            eval      = (r_run_len != '0);
            n_run_len = '0;
        end

        // one run against the trackers
        if (eval && !i_ctl.count && !r_hit) begin
            if (!r_any) begin
                n_any = 1'b1;
                n_ff  = r_run_st;
            end
            unique case (i_policy)
                bea_pkg::FIT_FIRST: begin
                    if (r_run_len >= i_need) begin
                        n_hit = 1'b1; n_h_st = r_run_st; n_h_take = i_need;
                    end
                end
                bea_pkg::FIT_BEST: begin
                    if (r_run_len == i_need) begin
                        n_hit = 1'b1; n_h_st = r_run_st; n_h_take = i_need;
                    end
                    if (r_run_len > i_need && (!r_big || r_run_len < r_a_len)) begin
                        n_big = 1'b1; n_a_st = r_run_st; n_a_len = r_run_len;
                    end
                    if (r_run_len < i_need && (!r_small || r_run_len > r_b_len)) begin
                        n_small = 1'b1; n_b_st = r_run_st; n_b_len = r_run_len;
                    end
                end
                default: begin
                    if (r_run_len > r_a_len) begin
                        n_a_st = r_run_st; n_a_len = r_run_len;
                    end
                end
            endcase
        end

        if (i_ctl.start) begin
            n_run_len = '0;
            n_any = 1'b0; n_big = 1'b0; n_small = 1'b0; n_hit = 1'b0;
            n_a_len = '0; n_b_len = '0; n_ones = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len <= '0;
            r_any <= 1'b0; r_big <= 1'b0; r_small <= 1'b0; r_hit <= 1'b0;
            r_a_len <= '0; r_b_len <= '0; r_ones <= '0;
        end else begin
            r_run_len <= n_run_len;
            r_any <= n_any; r_big <= n_big; r_small <= n_small; r_hit <= n_hit;
            r_a_len <= n_a_len; r_b_len <= n_b_len; r_ones <= n_ones;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_st <= n_run_st;
        r_ff     <= n_ff;
        r_a_st   <= n_a_st;
        r_b_st   <= n_b_st;
        r_h_st   <= n_h_st;
        r_h_take <= n_h_take;
    end

    always_comb begin
        o_res.hit = r_hit;
        o_res.any = r_any;
        if (r_hit) begin
            o_res.st = r_h_st; o_res.take = r_h_take;
        end else begin
            unique case (i_policy)
                bea_pkg::FIT_FIRST: begin
                    o_res.st = r_ff; o_res.take = LW'(1);
                end
                bea_pkg::FIT_BEST: begin
                    if (r_big) begin
                        o_res.st = r_a_st; o_res.take = i_need;
                    end else begin
                        o_res.st = r_b_st; o_res.take = r_b_len;
                    end
                end
                default: begin
                    o_res.st   = r_a_st;
                    o_res.take = (r_a_len < i_need) ? r_a_len : i_need;
                end
            endcase
        end
    end

    assign o_ones = r_ones;

endmodule

### rtl/core/bitmap_extent_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_extent_allocator_core
// Free-cluster bitmap with format, first/best/worst fit allocate, free, query.
// ----------------------------------------------------------------------------
//  channel   signals                                dir
//  request   i_in_valid / o_in_ready + fields       in
//  result    o_out_valid / i_out_ready + fields     out
//  config    i_cfg_we / i_cfg_wdata (cluster_total) in
//
// A scan walks the bitmap one bit per cycle through its single read port.
// Format writes every cluster; free reads, then writes, each cluster in range.
// Allocate: a count pass over [start, n), then per chunk a scan from start
// up to n plus one clear per cluster taken; extents are then read out in order.
// After reset an S_INIT pass clears all 2048 bits before the first request.
// A stalled result holds the block; no request is taken until it is done.
module bitmap_extent_allocator_core #(
    parameter int MAX_EXTENTS = bea_pkg::MAX_EXTENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [12:0] i_sector_count,
    input  logic [1:0]  i_fit_policy,
    input  logic [10:0] i_start_cluster,
    input  logic [11:0] i_run_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [10:0] o_extent_start,
    output logic [11:0] o_extent_length,
    output logic        o_last,
    output logic [11:0] o_free_count
);

    localparam int AW = bea_pkg::AW;
    localparam int LW = bea_pkg::LW;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FMT   = 4'd1;
    localparam logic [3:0] S_FR_RD = 4'd2;
    localparam logic [3:0] S_FR_WR = 4'd3;
    localparam logic [3:0] S_SCINI = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_CHOOS = 4'd7;
    localparam logic [3:0] S_CLR   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_E_RD  = 4'd10;
    localparam logic [3:0] S_E_LD  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_INIT  = 4'd13;

    logic [3:0]    r_state;
    logic [LW-1:0] r_ctotal, r_free_total, r_rem;
    logic [12:0]   r_need;
    logic [1:0]    r_pol;
    logic [AW-1:0] r_s;
    logic [12:0]   r_fend, r_cend;
    logic [LW-1:0] r_ptr;
    logic          r_qv, r_count_mode, r_trunc;
    logic [AW-1:0] r_qi;
    logic [CW-1:0] r_cnt, r_k;
    logic [AW-1:0] r_last_st;
    logic [LW-1:0] r_last_len, r_take;

    logic [AW+LW-1:0] r_ext [MAX_EXTENTS];
    logic [AW+LW-1:0] r_ext_q;
    logic          ext_we;

    logic [LW-1:0] n_use;
    logic          bm_we, bm_wdata, bm_q;
    logic [AW-1:0] bm_waddr;
    bea_pkg::t_scan_ctl scan_ctl;
    bea_pkg::t_scan_res scan_res;
    logic [LW-1:0] ones;
    logic [12:0]   ext_end;

    assign n_use      = (r_ctotal >= LW'(bea_pkg::MAX_CLUSTERS)) ?
                        LW'(bea_pkg::MAX_CLUSTERS) : r_ctotal;
    assign o_in_ready = (r_state == S_IDLE);
    assign ext_end    = {2'b00, r_last_st} + {1'b0, r_last_len};

    bea_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (bm_q)
    );

    bea_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_policy (r_pol),
        .i_need   (r_rem),
        .o_res    (scan_res),
        .o_ones   (ones)
    );

    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = r_ptr[AW-1:0];
        bm_wdata = 1'b0;
        unique case (r_state)
            S_INIT:  bm_we = 1'b1;
            S_FMT: begin
                bm_we    = 1'b1;
                bm_wdata = (r_ptr >= LW'(2)) && ({1'b0, r_ptr} + 13'd2 < {1'b0, n_use});
            end
            S_FR_WR: begin
                bm_we    = 1'b1;
                bm_wdata = 1'b1;
            end
            S_CLR:   bm_we = 1'b1;
            default: bm_we = 1'b0;
        endcase
    end

    always_comb begin
        scan_ctl         = '0;
        scan_ctl.count   = r_count_mode;
        scan_ctl.bit_idx = r_qi;
        if (r_state == S_SCINI) begin
            scan_ctl.start = 1'b1;
        end
        if (r_state == S_SCAN && !scan_res.hit) begin
            scan_ctl.bit_vld = r_qv;
            scan_ctl.bit_val = bm_q;
            scan_ctl.flush   = !r_qv && (r_ptr >= n_use);
        end
    end

    // extent list; the newest extent lives in r_last_* until a new one opens
    assign ext_we = (r_state == S_CHOOS) && scan_res.any && (r_cnt != '0) &&
                    (ext_end != {2'b00, scan_res.st}) && (r_cnt != CW'(MAX_EXTENTS));

    always_ff @(posedge i_clk) begin
        if (ext_we) begin
            r_ext[IW'(r_cnt - CW'(1))] <= {r_last_st, r_last_len};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ext_q <= r_ext[IW'(r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_ptr        <= '0;
            r_ctotal     <= bea_pkg::CLUSTER_TOTAL_RST;
            r_free_total <= '0;
            o_out_valid  <= 1'b0;
            r_qv         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ctotal <= i_cfg_wdata;
            end
            unique case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + LW'(1);
                    if (r_ptr == LW'(bea_pkg::MAX_CLUSTERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pol  <= i_fit_policy;
                        r_s    <= i_start_cluster;
                        r_need <= 13'(({1'b0, i_sector_count} + 14'd1) >> 1);
                        r_fend <= ({2'b00, i_start_cluster} + {1'b0, i_run_length}
                                   < {1'b0, n_use}) ?
                                  {2'b00, i_start_cluster} + {1'b0, i_run_length} :
                                  {1'b0, n_use};
                        r_ptr  <= (i_operation == bea_pkg::OP_FORMAT) ? '0 :
                                  {1'b0, i_start_cluster};
                        r_count_mode <= 1'b1;
                        unique case (i_operation)
                            bea_pkg::OP_FORMAT: r_state <= S_FMT;
                            bea_pkg::OP_ALLOC:  r_state <= S_SCINI;
                            bea_pkg::OP_FREE:   r_state <= S_FR_RD;
                            default: begin
                                o_status        <= bea_pkg::ST_OK;
                                o_extent_start  <= '0;
                                o_extent_length <= '0;
                                o_last          <= 1'b1;
                                o_free_count    <= r_free_total;
                                o_out_valid     <= 1'b1;
                                r_state         <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FMT: begin
                    r_ptr <= r_ptr + LW'(1);
                    if (r_ptr == LW'(bea_pkg::MAX_CLUSTERS - 1)) begin
                        r_free_total    <= (n_use >= LW'(4)) ? n_use - LW'(4) : '0;
                        o_status        <= bea_pkg::ST_OK;
                        o_extent_start  <= '0;
                        o_extent_length <= '0;
                        o_last          <= 1'b1;
                        o_free_count    <= (n_use >= LW'(4)) ? n_use - LW'(4) : '0;
                        o_out_valid     <= 1'b1;
                        r_state         <= S_OUT;
                    end
                end
                S_FR_RD: begin
                    if ({1'b0, r_ptr} >= r_fend) begin
                        o_status        <= bea_pkg::ST_OK;
                        o_extent_start  <= '0;
                        o_extent_length <= '0;
                        o_last          <= 1'b1;
                        o_free_count    <= r_free_total;
                        o_out_valid     <= 1'b1;
                        r_state         <= S_OUT;
                    end else begin
                        r_state <= S_FR_WR;
                    end
                end
                S_FR_WR: begin
                    if (!bm_q) begin
                        r_free_total <= r_free_total + LW'(1);
                    end
                    r_ptr   <= r_ptr + LW'(1);
                    r_state <= S_FR_RD;
                end
                S_SCINI: begin
                    r_ptr   <= {1'b0, r_s};
                    r_qv    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_res.hit || (!r_qv && r_ptr >= n_use)) begin
                        r_qv    <= 1'b0;
                        r_state <= r_count_mode ? S_CHECK : S_CHOOS;
                    end else if (r_ptr < n_use) begin
                        r_qv  <= 1'b1;
                        r_qi  <= r_ptr[AW-1:0];
                        r_ptr <= r_ptr + LW'(1);
                    end else begin
                        r_qv <= 1'b0;
                    end
                end
                S_CHECK: begin
                    o_extent_start  <= '0;
                    o_extent_length <= '0;
                    o_last          <= 1'b1;
                    o_free_count    <= r_free_total;
                    r_count_mode    <= 1'b0;
                    r_cnt           <= '0;
                    r_trunc         <= 1'b0;
                    r_rem           <= r_need[LW-1:0];
                    if (r_need > {1'b0, r_free_total} || r_need > {1'b0, ones}) begin
                        o_status    <= bea_pkg::ST_NOSPC;
                        o_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (r_pol == bea_pkg::FIT_BAD) begin
                        o_status    <= bea_pkg::ST_BADPOL;
                        o_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (r_need == '0) begin
                        o_status    <= bea_pkg::ST_OK;
                        o_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_SCINI;
                    end
                end
                S_CHOOS: begin
                    r_ptr  <= {1'b0, scan_res.st};
                    r_cend <= {2'b00, scan_res.st} + {1'b0, scan_res.take};
                    r_take <= scan_res.take;
                    priority if (!scan_res.any) begin
                        r_state <= S_DONE;
                    end else if (r_cnt != '0 && ext_end == {2'b00, scan_res.st}) begin
                        r_last_len <= r_last_len + scan_res.take;
                        r_state    <= S_CLR;
                    end else if (r_cnt == CW'(MAX_EXTENTS)) begin
                        r_trunc <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_last_st  <= scan_res.st;
                        r_last_len <= scan_res.take;
                        r_cnt      <= r_cnt + CW'(1);
                        r_state    <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_free_total <= r_free_total - LW'(1);
                    r_ptr        <= r_ptr + LW'(1);
                    if ({1'b0, r_ptr} + 13'd1 == r_cend) begin
                        r_rem   <= r_rem - r_take;
                        r_state <= (r_rem == r_take) ? S_DONE : S_SCINI;
                    end
                end
                S_DONE: begin
                    r_k <= '0;
                    if (r_cnt == '0) begin
                        o_status        <= bea_pkg::ST_OK;
                        o_extent_start  <= '0;
                        o_extent_length <= '0;
                        o_last          <= 1'b1;
                        o_free_count    <= r_free_total;
                        o_out_valid     <= 1'b1;
                        r_state         <= S_OUT;
                    end else begin
                        r_state <= S_E_RD;
                    end
                end
                S_E_RD: begin
                    o_status     <= r_trunc ? bea_pkg::ST_TRUNC : bea_pkg::ST_OK;
                    o_free_count <= r_free_total;
                    if (r_k == r_cnt - CW'(1)) begin
                        o_extent_start  <= r_last_st;
                        o_extent_length <= r_last_len;
                        o_last          <= 1'b1;
                        o_out_valid     <= 1'b1;
                        r_state         <= S_OUT;
                    end else begin
                        r_state <= S_E_LD;
                    end
                end
                S_E_LD: begin
                    o_extent_start  <= r_ext_q[AW+LW-1:LW];
                    o_extent_length <= r_ext_q[LW-1:0];
                    o_last          <= 1'b0;
                    o_out_valid     <= 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_E_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### bench/tb_bitmap_extent_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_extent_allocator_core
// Drives format/allocate/free/query requests under random idling and checks
// every result against a behavioral bitmap predictor or a directed expected value.
// ----------------------------------------------------------------------------
module tb_bitmap_extent_allocator_core;

    localparam longint CYCLE_LIMIT = 200_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] ext_start;
        logic [11:0] ext_len;
        logic        last;
        logic [11:0] free_cnt;
    } t_result;

    typedef struct packed {
        bit          is_cfg;
        logic [11:0] cfg_val;
        logic [1:0]  op;
        logic [12:0] sectors;
        logic [1:0]  policy;
        logic [10:0] start;
        logic [11:0] run_len;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [11:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = '0;
    logic [12:0] i_sector_count = '0;
    logic [1:0]  i_fit_policy = '0;
    logic [10:0] i_start_cluster = '0;
    logic [11:0] i_run_length = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [10:0] o_extent_start;
    logic [11:0] o_extent_length;
    logic        o_last;
    logic [11:0] o_free_count;

    bitmap_extent_allocator_core dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    bit          free_bits [bea_pkg::MAX_CLUSTERS];
    int unsigned free_sum;
    int unsigned total_cfg = bea_pkg::CLUSTER_TOTAL_RST;
    t_result     pending_q [$];

    int  err_cnt, req_cnt, res_cnt, ext_cnt, trunc_cnt;
    longint cyc;
    bit  quiet;

    function automatic int unsigned clusters_used();
        return (total_cfg < bea_pkg::MAX_CLUSTERS) ? total_cfg : bea_pkg::MAX_CLUSTERS;
    endfunction

    function automatic void recount_free();
        int unsigned c;
        c = 0;
        for (int i = 0; i < bea_pkg::MAX_CLUSTERS; i++) c += free_bits[i];
        free_sum = c & 12'hFFF;
    endfunction

    function automatic int unsigned run_from(int unsigned i, int unsigned n);
        int unsigned len;
        len = 0;
        while (i + len < n && free_bits[i + len]) len++;
        return len;
    endfunction

    function automatic bit pick_chunk(logic [1:0] pol, int unsigned s, int unsigned n,
                                      int unsigned need, output int unsigned st,
                                      output int unsigned take);
        int unsigned i, len, first_free, a_st, a_len, b_st, b_len;
        bit any, big, shrt;
        i = s; any = 0; big = 0; shrt = 0;
        first_free = 0; a_st = 0; a_len = 0; b_st = 0; b_len = 0;
        st = 0; take = 0;
        while (i < n) begin
            if (!free_bits[i]) begin
                i++;
                continue;
            end
            len = run_from(i, n);
            if (!any) begin
                any = 1;
                first_free = i;
            end
            if (pol == bea_pkg::FIT_FIRST) begin
                if (len >= need) begin
                    st = i; take = need;
                    return 1;
                end
            end else if (pol == bea_pkg::FIT_BEST) begin
                if (len == need) begin
                    st = i; take = need;
                    return 1;
                end
                if (len > need && (!big || len < a_len)) begin
                    big = 1; a_st = i; a_len = len;
                end
                if (len < need && (!shrt || len > b_len)) begin
                    shrt = 1; b_st = i; b_len = len;
                end
            end else if (len > a_len) begin
                a_st = i; a_len = len;
            end
            i += len;
        end
        if (!any) return 0;
        if (pol == bea_pkg::FIT_FIRST) begin
            st = first_free; take = 1;
        end else if (pol == bea_pkg::FIT_BEST) begin
            if (big) begin
                st = a_st; take = need;
            end else begin
                st = b_st; take = b_len;
            end
        end else begin
            st = a_st; take = (a_len < need) ? a_len : need;
        end
        return 1;
    endfunction

    function automatic t_result mk(logic [1:0] status, int unsigned st, int unsigned len,
                                   bit last);
        t_result r;
        r.status = status; r.ext_start = st[10:0]; r.ext_len = len[11:0];
        r.last = last; r.free_cnt = free_sum[11:0];
        return r;
    endfunction

    // computes a request's results, updates the map; pushes them, or want if typed
    function automatic void predict_alloc_map(logic [1:0] op, logic [12:0] sectors,
                                              logic [1:0] pol, logic [10:0] start,
                                              logic [11:0] rl, bit typed, t_result want);
        int unsigned n, c, s, window, rem, st, take, cnt;
        int unsigned e_st [bea_pkg::MAX_EXTENTS_DEF];
        int unsigned e_len [bea_pkg::MAX_EXTENTS_DEF];
        bit trunc;
        t_result got [$];
        n = clusters_used();
        c = (int'(sectors) + 1) / 2;
        s = start;
        cnt = 0; trunc = 0; window = 0;
        case (op)
            bea_pkg::OP_FORMAT: begin
                for (int i = 0; i < bea_pkg::MAX_CLUSTERS; i++)
                    free_bits[i] = (i < n && i >= 2 && i + 2 < n);
                recount_free();
                got.push_back(mk(bea_pkg::ST_OK, 0, 0, 1));
            end
            bea_pkg::OP_FREE: begin
                for (int unsigned i = s; i < s + rl && i < n; i++) free_bits[i] = 1;
                recount_free();
                got.push_back(mk(bea_pkg::ST_OK, 0, 0, 1));
            end
            bea_pkg::OP_QUERY: got.push_back(mk(bea_pkg::ST_OK, 0, 0, 1));
            default: begin
                for (int unsigned i = s; i < n; i++) window += free_bits[i];
                if (c > free_sum || c > window) begin
                    got.push_back(mk(bea_pkg::ST_NOSPC, 0, 0, 1));
                end else if (pol == bea_pkg::FIT_BAD) begin
                    got.push_back(mk(bea_pkg::ST_BADPOL, 0, 0, 1));
                end else begin
                    rem = c;
                    while (rem > 0) begin
                        if (!pick_chunk(pol, s, n, rem, st, take) || take == 0) break;
                        if (cnt > 0 && e_st[cnt-1] + e_len[cnt-1] == st) begin
                            e_len[cnt-1] += take;
                        end else if (cnt == bea_pkg::MAX_EXTENTS_DEF) begin
                            trunc = 1;
                            break;
                        end else begin
                            e_st[cnt] = st; e_len[cnt] = take; cnt++;
                        end
                        for (int unsigned i = st; i < st + take && i < n; i++)
                            free_bits[i] = 0;
                        rem -= take;
                    end
                    recount_free();
                    if (cnt == 0) got.push_back(mk(bea_pkg::ST_OK, 0, 0, 1));
                    for (int unsigned k = 0; k < cnt; k++)
                        got.push_back(mk(trunc ? bea_pkg::ST_TRUNC : bea_pkg::ST_OK,
                                         e_st[k], e_len[k], k == cnt - 1));
                    if (trunc) trunc_cnt++;
                end
            end
        endcase
        if (typed) pending_q.push_back(want);
        else foreach (got[k]) pending_q.push_back(got[k]);
    endfunction

    task automatic send_req(logic [1:0] op, logic [12:0] sectors, logic [1:0] pol,
                            logic [10:0] start, logic [11:0] rl, bit typed = 0,
                            t_result want = '0);
        if (!quiet && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_sector_count  <= sectors;
        i_fit_policy    <= pol;
        i_start_cluster <= start;
        i_run_length    <= rl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_alloc_map(op, sectors, pol, start, rl, typed, want);
        req_cnt++;
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_cluster_total(logic [11:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        total_cfg = v;
        @(posedge i_clk);
    endtask

    task automatic random_req();
        int unsigned n, pick;
        logic [1:0] pol;
        n = clusters_used();
        pick = $urandom_range(99);
        pol = ($urandom_range(9) == 0) ? bea_pkg::FIT_BAD
            : 2'($urandom_range(bea_pkg::FIT_FIRST, bea_pkg::FIT_WORST));
        if (pick < 5) begin
            send_req(bea_pkg::OP_FORMAT, 13'($urandom), 2'($urandom), 11'($urandom),
                     12'($urandom));
        end else if (pick < 55) begin
            if ($urandom_range(19) == 0)
                send_req(bea_pkg::OP_ALLOC, 13'($urandom_range(0, 4096)), pol,
                         11'($urandom_range(0, 2047)), 12'($urandom));
            else
                send_req(bea_pkg::OP_ALLOC, 13'($urandom_range(0, n / 4)), pol,
                         11'($urandom_range(0, n / 3)), 12'($urandom));
        end else if (pick < 85) begin
            if ($urandom_range(19) == 0)
                send_req(bea_pkg::OP_FREE, 13'($urandom), 2'($urandom),
                         11'($urandom_range(0, 2047)), 12'($urandom_range(0, 2048)));
            else
                send_req(bea_pkg::OP_FREE, 13'($urandom), 2'($urandom),
                         11'($urandom_range(0, n)), 12'($urandom_range(1, n / 8 + 1)));
        end else begin
            send_req(bea_pkg::OP_QUERY, 13'($urandom), 2'($urandom), 11'($urandom),
                     12'($urandom));
        end
    endtask

    t_row dir_rows [$];

    function automatic t_row rq(logic [1:0] op, logic [12:0] sec, logic [1:0] pol,
                                logic [10:0] st, logic [11:0] rl);
        t_row r;
        r = '0;
        r.op = op; r.sectors = sec; r.policy = pol; r.start = st; r.run_len = rl;
        return r;
    endfunction

    function automatic t_row rt(t_row r, logic [1:0] status, int unsigned st,
                                int unsigned len, int unsigned free_cnt);
        r.typed = 1;
        r.want = '{status: status, ext_start: st[10:0], ext_len: len[11:0], last: 1'b1,
                   free_cnt: free_cnt[11:0]};
        return r;
    endfunction

    function automatic t_row rc(logic [11:0] v);
        t_row r;
        r = '0;
        r.is_cfg = 1; r.cfg_val = v;
        return r;
    endfunction

    always @(posedge i_clk) i_out_ready <= quiet || ($urandom_range(99) >= 7);

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            res_cnt++;
            if (o_extent_length != 0) ext_cnt++;
            if (pending_q.size() == 0) begin
                $error("result with nothing pending: status %0d start %0d len %0d",
                       o_status, o_extent_start, o_extent_length);
                err_cnt++;
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    err_cnt++;
                end
                if (o_extent_start !== e.ext_start) begin
                    $error("extent_start: expected %0d, got %0d", e.ext_start, o_extent_start);
                    err_cnt++;
                end
                if (o_extent_length !== e.ext_len) begin
                    $error("extent_length: expected %0d, got %0d", e.ext_len, o_extent_length);
                    err_cnt++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    err_cnt++;
                end
                if (o_free_count !== e.free_cnt) begin
                    $error("free_count: expected %0d, got %0d", e.free_cnt, o_free_count);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout, %0d results still pending", pending_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned phase_totals [5];
        phase_totals = '{64, 300, 37, 128, 1024};
        for (int i = 0; i < bea_pkg::MAX_CLUSTERS; i++) free_bits[i] = 0;
        free_sum = 0;

        // directed rows over all operations and fit policies; c = (sectors + 1) / 2
        dir_rows.push_back(rt(rq(bea_pkg::OP_FORMAT, 0, 0, 0, 0), bea_pkg::ST_OK, 0, 0,
                              1596));
        dir_rows.push_back(rt(rq(bea_pkg::OP_QUERY, 0, 0, 0, 0), bea_pkg::ST_OK, 0, 0,
                              1596));
        dir_rows.push_back(rt(rq(bea_pkg::OP_ALLOC, 4096, bea_pkg::FIT_FIRST, 0, 0),
                              bea_pkg::ST_NOSPC, 0, 0, 1596));
        dir_rows.push_back(rt(rq(bea_pkg::OP_ALLOC, 2, bea_pkg::FIT_FIRST, 2047, 0),
                              bea_pkg::ST_NOSPC, 0, 0, 1596));
        dir_rows.push_back(rt(rq(bea_pkg::OP_ALLOC, 10, bea_pkg::FIT_BAD, 0, 0),
                              bea_pkg::ST_BADPOL, 0, 0, 1596));
        dir_rows.push_back(rt(rq(bea_pkg::OP_ALLOC, 0, bea_pkg::FIT_BEST, 0, 0),
                              bea_pkg::ST_OK, 0, 0, 1596));
        dir_rows.push_back(rt(rq(bea_pkg::OP_ALLOC, 9, bea_pkg::FIT_FIRST, 0, 0),
                              bea_pkg::ST_OK, 2, 5, 1591));
        dir_rows.push_back(rq(bea_pkg::OP_ALLOC, 20, bea_pkg::FIT_WORST, 100, 0));
        dir_rows.push_back(rq(bea_pkg::OP_ALLOC, 3000, bea_pkg::FIT_FIRST, 0, 0));
        dir_rows.push_back(rq(bea_pkg::OP_FREE, 0, 0, 50, 20));
        dir_rows.push_back(rq(bea_pkg::OP_FREE, 0, 0, 300, 7));
        dir_rows.push_back(rq(bea_pkg::OP_ALLOC, 40, bea_pkg::FIT_BEST, 0, 0));
        dir_rows.push_back(rq(bea_pkg::OP_ALLOC, 30, bea_pkg::FIT_BEST, 0, 0));
        dir_rows.push_back(rq(bea_pkg::OP_FREE, 0, 0, 1590, 2048));
        dir_rows.push_back(rq(bea_pkg::OP_ALLOC, 8, bea_pkg::FIT_WORST, 1597, 0));
        dir_rows.push_back(rc(12'd4));
        dir_rows.push_back(rt(rq(bea_pkg::OP_FORMAT, 0, 0, 0, 0), bea_pkg::ST_OK, 0, 0, 0));
        dir_rows.push_back(rt(rq(bea_pkg::OP_FREE, 0, 0, 0, 2048), bea_pkg::ST_OK, 0, 0, 4));
        dir_rows.push_back(rt(rq(bea_pkg::OP_ALLOC, 8, bea_pkg::FIT_FIRST, 0, 0),
                              bea_pkg::ST_OK, 0, 4, 0));
        dir_rows.push_back(rc(12'd2048));
        dir_rows.push_back(rt(rq(bea_pkg::OP_FORMAT, 0, 0, 0, 0), bea_pkg::ST_OK, 0, 0,
                              2044));
        dir_rows.push_back(rt(rq(bea_pkg::OP_ALLOC, 4088, bea_pkg::FIT_BEST, 0, 0),
                              bea_pkg::ST_OK, 2, 2044, 0));
        dir_rows.push_back(rq(bea_pkg::OP_FREE, 0, 0, 2047, 1));
        dir_rows.push_back(rq(bea_pkg::OP_QUERY, 0, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) set_cluster_total(dir_rows[k].cfg_val);
            else send_req(dir_rows[k].op, dir_rows[k].sectors, dir_rows[k].policy,
                          dir_rows[k].start, dir_rows[k].run_len, dir_rows[k].typed,
                          dir_rows[k].want);
        end

        // fragment the map into single free clusters so allocation overflows
        // the extent list; no idling on either side here
        set_cluster_total(12'd256);
        quiet = 1;
        send_req(bea_pkg::OP_FORMAT, 0, 0, 0, 0);
        send_req(bea_pkg::OP_ALLOC, 504, bea_pkg::FIT_FIRST, 0, 0);
        for (int i = 0; i < 70; i++) send_req(bea_pkg::OP_FREE, 0, 0, 11'(4 + 2 * i), 1);
        send_req(bea_pkg::OP_ALLOC, 140, bea_pkg::FIT_WORST, 0, 0);
        quiet = 0;

        foreach (phase_totals[p]) begin
            set_cluster_total(phase_totals[p][11:0]);
            send_req(bea_pkg::OP_FORMAT, 0, 0, 0, 0);
            repeat (12) random_req();
        end

        drain_results();
        $display("%0d requests, %0d results, %0d extents, %0d truncated allocations",
                 req_cnt, res_cnt, ext_cnt, trunc_cnt);
        $display("cluster totals 4 to 2048, all fit policies, space and policy errors");
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
